@@ sv/hash_ring_replica_placement_unit_assert.svh @@
// Assertion macros shared by the placement unit.
`ifndef HASH_RING_REPLICA_PLACEMENT_UNIT_ASSERT_SVH
`define HASH_RING_REPLICA_PLACEMENT_UNIT_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define HRP_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");

// Condition that must never hold outside reset.
`define HRP_ASSERT_NEVER(lbl, clk, rstn, a) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(a)) \
    else $error("assertion failed");

`endif

@@ sv/hrp_pkg.sv @@
package hrp_pkg;

  localparam int unsigned RingDepthDef   = 256;
  localparam int unsigned MaxReplicasDef = 8;

  localparam logic [63:0] HashBasis = 64'hcbf29ce484222325;
  localparam logic [63:0] HashPrime = 64'h00000100000001b3;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StCollision = 2'd1,
    StFull      = 2'd2,
    StNoPoint   = 2'd3
  } status_e;

  typedef enum logic {
    CmdInsert = 1'b0,
    CmdMap    = 1'b1
  } cmd_e;

  localparam logic [1:0] RegReplicaCount = 2'd0;

  typedef struct packed {
    logic        cmd;
    logic [63:0] point_hash;
    logic [31:0] point_zone;
    logic [63:0] object_id;
  } in_item_t;

  typedef struct packed {
    logic [31:0] zone_out;
    logic [7:0]  slot_out;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // Classified work handed from front to back.
  typedef struct packed {
    logic        is_map;
    logic [63:0] key;     // point hash or object hash
    logic [31:0] zone;
  } job_t;

  typedef enum logic [2:0] {
    FrIdle,
    FrHash,
    FrPush
  } front_state_e;

  typedef enum logic [3:0] {
    BkIdle,
    BkSearch,
    BkSearchWait,
    BkShift,
    BkShiftWait,
    BkWrite,
    BkFirst,
    BkWalk,
    BkWalkWait,
    BkCheck,
    BkDone
  } back_state_e;

endpackage

@@ sv/hrp_front.sv @@
// Front: accepts items, hashes object ids one byte per step (16 steps).
module hrp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  hrp_pkg::in_item_t item_i,
  input  logic              fifo_full_i,
  output logic              busy_o,
  output logic              push_o,
  output hrp_pkg::job_t     job_o
);

  hrp_pkg::front_state_e state_q, state_d;
  logic [63:0] h_q, h_d;
  logic [63:0] v_q, v_d;
  logic [3:0]  step_q, step_d;
  hrp_pkg::job_t job_q, job_d;
  logic [63:0] mixed;

  assign mixed = (h_q ^ {56'd0, v_q[7:0]}) * hrp_pkg::HashPrime;

  always_comb begin
    state_d = state_q;
    case (state_q)
      hrp_pkg::FrIdle: begin
        if (start_i) begin
          state_d = (item_i.cmd == hrp_pkg::CmdMap) ? hrp_pkg::FrHash : hrp_pkg::FrPush;
        end
      end
      hrp_pkg::FrHash: if (step_q == 4'd15) state_d = hrp_pkg::FrPush;
      hrp_pkg::FrPush: if (!fifo_full_i) state_d = hrp_pkg::FrIdle;
      default: state_d = hrp_pkg::FrIdle;
    endcase
  end

  always_comb begin
    h_d = h_q;
    v_d = v_q;
    step_d = step_q;
    job_d = job_q;
    case (state_q)
      hrp_pkg::FrIdle: begin
        h_d = hrp_pkg::HashBasis;
        v_d = item_i.object_id;
        step_d = 4'd0;
        job_d.is_map = item_i.cmd;
        job_d.key = item_i.point_hash;
        job_d.zone = item_i.point_zone;
      end
      hrp_pkg::FrHash: begin
        h_d = mixed;
        step_d = step_q + 4'd1;
        // after the first pass the seed and the data are both its result
        v_d = (step_q == 4'd7) ? mixed : {8'd0, v_q[63:8]};
        if (step_q == 4'd15) job_d.key = mixed;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hrp_pkg::FrIdle;
      step_q <= 4'd0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    v_q <= v_d;
    job_q <= job_d;
  end

  assign busy_o = (state_q != hrp_pkg::FrIdle);
  assign push_o = (state_q == hrp_pkg::FrPush) && !fifo_full_i;
  assign job_o  = job_q;

  `include "hash_ring_replica_placement_unit_assert.svh"
  `HRP_ASSERT_IMP(a_push_from_push, clk_i, rst_ni, push_o, state_q == hrp_pkg::FrPush)
  `HRP_ASSERT_IMP(a_step_idle, clk_i, rst_ni, state_q == hrp_pkg::FrHash && step_q == 4'd15,
    state_d == hrp_pkg::FrPush)
  `HRP_ASSERT_IMP(a_hash_next, clk_i, rst_ni, state_q == hrp_pkg::FrIdle && start_i &&
    item_i.cmd == hrp_pkg::CmdMap, state_d == hrp_pkg::FrHash)

endmodule

@@ sv/hrp_fifo.sv @@
// Two-entry job queue.
module hrp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hrp_pkg::job_t data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output hrp_pkg::job_t data_o
);

  hrp_pkg::job_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  `include "hash_ring_replica_placement_unit_assert.svh"
  `HRP_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o)
  `HRP_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o)
  `HRP_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q == 2'd3)

endmodule

@@ sv/hrp_back.sv @@
// Back: sorted ring in memories; linear search, shift insert, successor walk.
module hrp_back #(
  parameter int unsigned RingDepth   = hrp_pkg::RingDepthDef,
  parameter int unsigned MaxReplicas = hrp_pkg::MaxReplicasDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  hrp_pkg::job_t      job_i,
  input  logic [3:0]         replica_count_i,
  output logic               pop_o,
  output logic               idle_o,
  output logic               valid_o,
  output hrp_pkg::out_item_t result_o
);

  localparam int unsigned IW = $clog2(RingDepth);
  localparam int unsigned FW = IW + 1;
  localparam int unsigned CW = (MaxReplicas > 1) ? $clog2(MaxReplicas) : 1;
  localparam int unsigned GW = $clog2(MaxReplicas + 1);

  logic [63:0] hmem [RingDepth];
  logic [31:0] zmem [RingDepth];
  logic [63:0] hrd_q;
  logic [31:0] zrd_q;

  hrp_pkg::back_state_e state_q, state_d;
  hrp_pkg::job_t job_q;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] idx_q, idx_d;      // search / shift / walk pointer
  logic [FW-1:0] first_q, first_d;
  logic [FW-1:0] pos_q, pos_d;
  logic [GW-1:0] got_q, got_d, want;
  logic [31:0] chosen_q [MaxReplicas];
  logic [CW-1:0] chk_q, chk_d;
  logic clash_q, clash_d;

  logic [IW-1:0] rd_addr;
  logic          we;
  logic [IW-1:0] wr_addr;
  logic [63:0]   wr_h;
  logic [31:0]   wr_z;
  logic [FW-1:0] nxt;

  always_comb begin
    if (replica_count_i == 4'd0) want = GW'(1);
    else if (32'(replica_count_i) > MaxReplicas) want = GW'(MaxReplicas);
    else want = GW'(replica_count_i);
  end

  assign nxt = (idx_q + FW'(1) >= fill_q) ? FW'(0) : idx_q + FW'(1);

  always_ff @(posedge clk_i) begin
    if (we) begin
      hmem[wr_addr] <= wr_h;
      zmem[wr_addr] <= wr_z;
    end
    hrd_q <= hmem[rd_addr];
    zrd_q <= zmem[rd_addr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hrp_pkg::BkIdle: if (!empty_i) state_d = hrp_pkg::BkSearch;
      hrp_pkg::BkSearch: begin
        if (fill_q == FW'(0)) state_d = hrp_pkg::BkDone;
        else if (idx_q >= fill_q) begin
          if (job_q.is_map) state_d = hrp_pkg::BkFirst;
          else if (fill_q >= FW'(RingDepth)) state_d = hrp_pkg::BkDone;
          else state_d = hrp_pkg::BkShift;
        end else state_d = hrp_pkg::BkSearchWait;
      end
      hrp_pkg::BkSearchWait: begin
        if (hrd_q >= job_q.key) begin
          if (job_q.is_map) state_d = hrp_pkg::BkFirst;
          else if (hrd_q == job_q.key || fill_q >= FW'(RingDepth))
            state_d = hrp_pkg::BkDone;
          else state_d = hrp_pkg::BkShift;
        end else state_d = hrp_pkg::BkSearch;
      end
      hrp_pkg::BkShift: state_d = (idx_q == pos_q) ? hrp_pkg::BkWrite : hrp_pkg::BkShiftWait;
      hrp_pkg::BkShiftWait: state_d = hrp_pkg::BkShift;
      hrp_pkg::BkWrite: state_d = hrp_pkg::BkIdle;
      hrp_pkg::BkFirst: state_d = hrp_pkg::BkWalk;
      hrp_pkg::BkWalk: state_d = (got_q >= want) ? hrp_pkg::BkIdle : hrp_pkg::BkWalkWait;
      hrp_pkg::BkWalkWait: state_d = hrp_pkg::BkCheck;
      hrp_pkg::BkCheck: begin
        if (idx_q == first_q) state_d = hrp_pkg::BkIdle;
        else if (32'(chk_q) + 1 >= 32'(got_q) || clash_q ||
                 chosen_q[chk_q] == zrd_q) begin
          state_d = hrp_pkg::BkWalk;
        end
      end
      hrp_pkg::BkDone: state_d = hrp_pkg::BkIdle;
      default: state_d = hrp_pkg::BkIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    fill_d = fill_q;
    idx_d = idx_q;
    first_d = first_q;
    pos_d = pos_q;
    got_d = got_q;
    chk_d = chk_q;
    clash_d = clash_q;
    rd_addr = idx_q[IW-1:0];
    we = 1'b0;
    wr_addr = idx_q[IW-1:0];
    wr_h = hrd_q;
    wr_z = zrd_q;
    pop_o = 1'b0;
    valid_o = 1'b0;
    result_o = '0;
    case (state_q)
      hrp_pkg::BkIdle: begin
        pop_o = !empty_i;
        idx_d = '0;
      end
      hrp_pkg::BkSearch: begin
        pos_d = idx_q;
        if (fill_q == FW'(0)) begin
          valid_o = 1'b1;
          if (job_q.is_map) result_o.status = hrp_pkg::StNoPoint;
          else begin
            result_o.zone_out = job_q.zone;
            result_o.status = hrp_pkg::StOk;
            we = 1'b1;
            wr_addr = '0;
            wr_h = job_q.key;
            wr_z = job_q.zone;
            fill_d = FW'(1);
          end
          result_o.last = 1'b1;
        end else if (idx_q >= fill_q) begin
          if (job_q.is_map) begin
            // no point at or above the hash: wrap to the smallest point
            idx_d = '0;
            rd_addr = '0;
          end else if (fill_q >= FW'(RingDepth)) begin
            valid_o = 1'b1;
            result_o.status = hrp_pkg::StFull;
            result_o.last = 1'b1;
          end else idx_d = fill_q;
        end
      end
      hrp_pkg::BkSearchWait: begin
        if (hrd_q >= job_q.key) begin
          if (!job_q.is_map) begin
            if (hrd_q == job_q.key || fill_q >= FW'(RingDepth)) begin
              valid_o = 1'b1;
              result_o.status = (hrd_q == job_q.key) ? hrp_pkg::StCollision
                                                     : hrp_pkg::StFull;
              result_o.last = 1'b1;
            end else idx_d = fill_q;
          end
        end else idx_d = idx_q + FW'(1);
      end
      hrp_pkg::BkShift: begin
        if (idx_q != pos_q) rd_addr = idx_q[IW-1:0] - IW'(1);
      end
      hrp_pkg::BkShiftWait: begin
        we = 1'b1;
        idx_d = idx_q - FW'(1);
      end
      hrp_pkg::BkWrite: begin
        we = 1'b1;
        wr_h = job_q.key;
        wr_z = job_q.zone;
        fill_d = fill_q + FW'(1);
        valid_o = 1'b1;
        result_o.zone_out = job_q.zone;
        result_o.slot_out = 8'(pos_q);
        result_o.status = hrp_pkg::StOk;
        result_o.last = 1'b1;
      end
      hrp_pkg::BkFirst: begin
        // memory data for idx (search hit) or slot 0 after wrap
        valid_o = 1'b1;
        result_o.zone_out = zrd_q;
        result_o.slot_out = 8'(idx_q);
        result_o.status = hrp_pkg::StOk;
        result_o.last = (want == GW'(1));
        first_d = idx_q;
        got_d = GW'(1);
      end
      hrp_pkg::BkWalk: begin
        idx_d = nxt;
        rd_addr = nxt[IW-1:0];
        chk_d = '0;
        clash_d = 1'b0;
      end
      hrp_pkg::BkCheck: begin
        if (idx_q == first_q) begin
          valid_o = 1'b1;
          result_o.status = hrp_pkg::StNoPoint;
          result_o.last = 1'b1;
        end else begin
          clash_d = clash_q || (chosen_q[chk_q] == zrd_q);
          chk_d = chk_q + CW'(1);
          if (32'(chk_q) + 1 >= 32'(got_q) && !clash_d) begin
            valid_o = 1'b1;
            result_o.zone_out = zrd_q;
            result_o.slot_out = 8'(idx_q);
            result_o.status = hrp_pkg::StOk;
            result_o.last = (got_q + GW'(1) == want);
            got_d = got_q + GW'(1);
          end
        end
      end
      hrp_pkg::BkDone: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hrp_pkg::BkIdle;
      fill_q <= '0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    idx_q <= idx_d;
    first_q <= first_d;
    pos_q <= pos_d;
    got_q <= got_d;
    chk_q <= chk_d;
    clash_q <= clash_d;
    if (state_q == hrp_pkg::BkFirst) chosen_q[0] <= zrd_q;
    if (state_q == hrp_pkg::BkCheck && got_d != got_q) chosen_q[got_q[CW-1:0]] <= zrd_q;
  end

  assign idle_o = (state_q == hrp_pkg::BkIdle);

  `include "hash_ring_replica_placement_unit_assert.svh"
  `HRP_ASSERT_NEVER(a_fill_range, clk_i, rst_ni, fill_q > FW'(RingDepth))
  `HRP_ASSERT_IMP(a_write_grows, clk_i, rst_ni, state_q == hrp_pkg::BkWrite,
    fill_q < FW'(RingDepth))
  `HRP_ASSERT_IMP(a_pop_idle, clk_i, rst_ni, pop_o, state_q == hrp_pkg::BkIdle)

endmodule

@@ sv/hash_ring_replica_placement_unit.sv @@
// Channel  | Signals                         | Handshake
// ---------+---------------------------------+-------------------------------
// item in  | start_i, busy_o, item_i         | beat when start_i && !busy_o
// result   | result_valid_o, result_o        | one-cycle strobe, no stall
// config   | psel/penable/pwrite/paddr/pwdata| APB, pready tied high
//
// Pacing: a map hashes one byte multiply per cycle in the front, then the
// back searches the ring (read and compare state per slot) and walks
// successors, checking each against the chosen replicas. Insert searches
// alike, then shifts slots with read and write states; memory reads pace it.
// Reset clears control and fill count; ring memories need no clearing.
// busy_o is high while the front hashes or holds a job for the queue.
module hash_ring_replica_placement_unit #(
  parameter int unsigned RingDepth   = hrp_pkg::RingDepthDef,
  parameter int unsigned MaxReplicas = hrp_pkg::MaxReplicasDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  hrp_pkg::in_item_t  item_i,
  output logic               result_valid_o,
  output hrp_pkg::out_item_t result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [3:0] replica_count_q;
  logic push, pop, full, empty, front_busy, back_idle;
  hrp_pkg::job_t job_in, job_out;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) replica_count_q <= 4'd1;
    else if (psel && penable && pwrite && paddr == hrp_pkg::RegReplicaCount)
      replica_count_q <= pwdata[3:0];
  end

  assign prdata = (paddr == hrp_pkg::RegReplicaCount) ? {28'd0, replica_count_q} : 32'd0;

  hrp_front u_front (
    .clk_i, .rst_ni, .start_i, .item_i,
    .fifo_full_i(full), .busy_o(front_busy), .push_o(push), .job_o(job_in)
  );

  hrp_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(job_in), .pop_i(pop),
    .full_o(full), .empty_o(empty), .data_o(job_out)
  );

  hrp_back #(.RingDepth(RingDepth), .MaxReplicas(MaxReplicas)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .job_i(job_out),
    .replica_count_i(replica_count_q), .pop_o(pop), .idle_o(back_idle),
    .valid_o(result_valid_o), .result_o
  );

  assign busy_o = front_busy;

  `include "hash_ring_replica_placement_unit_assert.svh"
  `HRP_ASSERT_IMP(a_pop_ok, clk_i, rst_ni, pop, !empty && back_idle)
  `HRP_ASSERT_NEVER(a_res_in_idle, clk_i, rst_ni, result_valid_o && back_idle)
  `HRP_ASSERT_IMP(a_rc_held, clk_i, rst_ni, !(psel && penable && pwrite),
    1'b1 ##1 $stable(replica_count_q))

endmodule
